@@ rtl/nlt_pkg.sv @@
// Shared types and constants of the neighbor liveness table.
package nlt_pkg;

  localparam int unsigned IDX_W      = 8;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned MAC_W      = 48;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned ST_W       = 8;
  localparam int unsigned LIMIT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [ST_W-1:0] STATE_REACH = 8'h02;
  localparam logic [ST_W-1:0] STATE_STALE = 8'h04;

  localparam logic [LIMIT_W-1:0] LIMIT_RST       = 5'd16;
  localparam logic [ST_W-1:0]    ALIVE_MASK_RST  = 8'h1E;
  localparam logic [ST_W-1:0]    FAILED_MASK_RST = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTRY_LIMIT = 2'd0,
    CFG_ALIVE_MASK  = 2'd1,
    CFG_FAILED_MASK = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic             cmd;
    logic             address_present;
    logic             address_is_v6;
    logic [KEY_W-1:0] address_high;
    logic [KEY_W-1:0] address_low;
    logic             is_deletion;
    logic [ST_W-1:0]  neighbor_state;
    logic             mac_present;
    logic [MAC_W-1:0] sta_mac;
  } in_beat_t;

  typedef struct packed {
    logic               identified;
    logic               peer_alive;
    logic               peer_failed;
    logic               tracked;
    logic               reach_mac_vld;
    logic [MAC_W-1:0]   reach_mac;
    logic               table_live;
    logic [LIMIT_W-1:0] entry_count;
  } out_beat_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_beat_t;

  typedef struct packed {
    logic             family;
    logic [KEY_W-1:0] key_high;
    logic [KEY_W-1:0] key_low;
    logic [MAC_W-1:0] sta_mac;
  } query_t;

  typedef struct packed {
    logic             ent_found;
    logic [IDX_W-1:0] ent_idx;
    logic             ent_mac_known;
    logic [MAC_W-1:0] ent_mac;
    logic [CNT_W-1:0] ent_cnt;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             sus_found;
    logic [IDX_W-1:0] sus_idx;
    logic [CNT_W-1:0] sus_cnt;
    logic             sus_free_found;
    logic [IDX_W-1:0] sus_free_idx;
    logic             table_live;
  } carry_t;

  typedef struct packed {
    logic             clear_all;
    logic             ent_del;
    logic             ent_upd;
    logic             ent_ins;
    logic [IDX_W-1:0] ent_idx;
    logic             sus_ins;
    logic             sus_clr;
    logic [IDX_W-1:0] sus_idx;
    logic             hit_clr;
    logic             rotate;
    logic [ST_W-1:0]  nstate;
    logic             mac_present;
    logic [MAC_W-1:0] mac;
  } wr_t;

endpackage

@@ rtl/nlt_in_if.sv @@
// Input channel of the neighbor liveness table.
interface nlt_in_if import nlt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/nlt_out_if.sv @@
// Result channel of the neighbor liveness table.
interface nlt_out_if import nlt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/nlt_cfg_if.sv @@
// Configuration write channel of the neighbor liveness table.
interface nlt_cfg_if import nlt_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/nlt_cell.sv @@
// One table cell: a neighbor slot, a suspect slot on the ring, and a scan stage.
module nlt_cell import nlt_pkg::*; #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  query_t           q,
  input  wr_t              wr,
  input  logic [ST_W-1:0]  alive_mask,
  input  logic             sus_valid_in,
  input  logic [MAC_W-1:0] sus_mac_in,
  output logic             sus_valid_out,
  output logic [MAC_W-1:0] sus_mac_out,
  input  carry_t           carry_in,
  output carry_t           carry_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic             ent_valid_r;
  logic             ent_family_r;
  logic [KEY_W-1:0] ent_key_high_r;
  logic [KEY_W-1:0] ent_key_low_r;
  logic [ST_W-1:0]  ent_state_r;
  logic             ent_mac_known_r;
  logic [MAC_W-1:0] ent_mac_r;
  logic             sus_valid_r;
  logic [MAC_W-1:0] sus_mac_r;
  logic             hit_r;
  carry_t           carry_r;
  carry_t           carry_nxt;

  logic ent_sel;
  logic sus_sel;
  logic key_eq;
  logic live;

  assign ent_sel = (wr.ent_idx == MY_IDX);
  assign sus_sel = (wr.sus_idx == MY_IDX);
  assign key_eq  = (ent_family_r == q.family) && (ent_key_high_r == q.key_high) &&
                   (ent_key_low_r == q.key_low);
  assign live    = ent_valid_r && ((ent_state_r & alive_mask) != '0) &&
                   !(((ent_state_r & STATE_STALE) != '0) && ent_mac_known_r && hit_r);

  always_comb begin
    carry_nxt = carry_in;
    if (ent_valid_r) begin
      carry_nxt.ent_cnt = carry_in.ent_cnt + CNT_W'(1);
      if (!carry_in.ent_found && key_eq) begin
        carry_nxt.ent_found     = 1'b1;
        carry_nxt.ent_idx       = MY_IDX;
        carry_nxt.ent_mac_known = ent_mac_known_r;
        carry_nxt.ent_mac       = ent_mac_r;
      end
    end else if (!carry_in.free_found) begin
      carry_nxt.free_found = 1'b1;
      carry_nxt.free_idx   = MY_IDX;
    end
    if (sus_valid_r) begin
      carry_nxt.sus_cnt = carry_in.sus_cnt + CNT_W'(1);
      if (!carry_in.sus_found && (sus_mac_r == q.sta_mac)) begin
        carry_nxt.sus_found = 1'b1;
        carry_nxt.sus_idx   = MY_IDX;
      end
    end else if (!carry_in.sus_free_found) begin
      carry_nxt.sus_free_found = 1'b1;
      carry_nxt.sus_free_idx   = MY_IDX;
    end
    carry_nxt.table_live = carry_in.table_live | live;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
      sus_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      if (wr.clear_all) begin
        ent_valid_r <= 1'b0;
      end else if (wr.ent_del && ent_sel) begin
        ent_valid_r <= 1'b0;
      end else if (wr.ent_ins && ent_sel) begin
        ent_valid_r <= 1'b1;
      end
      if (wr.clear_all) begin
        sus_valid_r <= 1'b0;
      end else if (wr.rotate) begin
        sus_valid_r <= sus_valid_in;
      end else if (wr.sus_ins && sus_sel) begin
        sus_valid_r <= 1'b1;
      end else if (wr.sus_clr && sus_sel) begin
        sus_valid_r <= 1'b0;
      end
      if (wr.hit_clr) begin
        hit_r <= 1'b0;
      end else if (wr.rotate && sus_valid_r && (sus_mac_r == ent_mac_r)) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
    if (wr.ent_ins && ent_sel) begin
      ent_family_r    <= q.family;
      ent_key_high_r  <= q.key_high;
      ent_key_low_r   <= q.key_low;
      ent_state_r     <= wr.nstate;
      ent_mac_known_r <= wr.mac_present;
      ent_mac_r       <= wr.mac_present ? wr.mac : '0;
    end else if (wr.ent_upd && ent_sel) begin
      ent_state_r <= wr.nstate;
      if (wr.mac_present) begin
        ent_mac_known_r <= 1'b1;
        ent_mac_r       <= wr.mac;
      end
    end
    if (wr.rotate) begin
      sus_mac_r <= sus_mac_in;
    end else if (wr.sus_ins && sus_sel) begin
      sus_mac_r <= q.sta_mac;
    end
  end

  assign sus_valid_out = sus_valid_r;
  assign sus_mac_out   = sus_mac_r;
  assign carry_out     = carry_r;

endmodule

@@ rtl/neighbor_liveness_table.sv @@
// Top level of the neighbor liveness table: cell row, sequencer and channels.
//
//   channel  dir  beat        handshake
//   in_ch    in   in_beat_t   valid/ready
//   out_ch   out  out_beat_t  valid/ready
//   cfg_ch   in   cfg_beat_t  valid/ready, always ready
//
// Each item passes through two scans of the cell row, a write step, one full turn of
// the suspect ring and a final scan, then waits for the output to be taken. One item
// in flight; in_ch is ready only when idle.
// Synchronous active-low reset empties both stores; no clearing pass.
module neighbor_liveness_table import nlt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input logic    clk,
  input logic    rst_n,
  nlt_in_if.sink   in_ch,
  nlt_out_if.source out_ch,
  nlt_cfg_if.sink  cfg_ch
);

  localparam int unsigned TW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN_A = 7'b0000010,
    ST_SCAN_B = 7'b0000100,
    ST_WRITE  = 7'b0001000,
    ST_ROTATE = 7'b0010000,
    ST_SCAN_C = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_t;

  state_t             state_r;
  logic [TW-1:0]      cnt_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [ST_W-1:0]    alive_mask_r;
  logic [ST_W-1:0]    failed_mask_r;
  in_beat_t           item_r;
  logic [MAC_W-1:0]   station_r;
  logic               have_station_r;
  carry_t             res_r;
  logic               tracked_r;
  logic               tracked_nxt;
  logic               out_valid_r;
  out_beat_t          out_r;
  wr_t                wr;
  query_t             q;

  carry_t           carry_w [TABLE_DEPTH];
  logic             sus_v_w [TABLE_DEPTH];
  logic [MAC_W-1:0] sus_m_w [TABLE_DEPTH];

  logic cnt_full;
  logic is_failed;
  logic is_reach;
  logic report;
  logic [CNT_W-1:0] limit_ext;

  assign cnt_full  = (cnt_r == TW'(TABLE_DEPTH));
  assign report    = !item_r.cmd && item_r.address_present;
  assign is_failed = (item_r.neighbor_state & failed_mask_r) != '0;
  assign is_reach  = !item_r.is_deletion && ((item_r.neighbor_state & STATE_REACH) != '0);
  assign limit_ext = CNT_W'(limit_r);

  assign q.family   = item_r.address_is_v6;
  assign q.key_high = item_r.address_high;
  assign q.key_low  = item_r.address_low;
  assign q.sta_mac  = station_r;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    nlt_cell #(.CELL_IDX(i)) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .q             (q),
      .wr            (wr),
      .alive_mask    (alive_mask_r),
      .sus_valid_in  (sus_v_w[(i + TABLE_DEPTH - 1) % TABLE_DEPTH]),
      .sus_mac_in    (sus_m_w[(i + TABLE_DEPTH - 1) % TABLE_DEPTH]),
      .sus_valid_out (sus_v_w[i]),
      .sus_mac_out   (sus_m_w[i]),
      .carry_in      ((i == 0) ? carry_t'('0) : carry_w[(i + TABLE_DEPTH - 1) % TABLE_DEPTH]),
      .carry_out     (carry_w[i])
    );
  end

  always_comb begin
    wr             = '0;
    tracked_nxt    = 1'b0;
    wr.nstate      = item_r.neighbor_state;
    wr.mac_present = item_r.mac_present;
    wr.mac         = item_r.sta_mac;
    wr.rotate      = (state_r == ST_ROTATE);
    if (state_r == ST_WRITE) begin
      wr.hit_clr = 1'b1;
      if (item_r.cmd) begin
        wr.clear_all = 1'b1;
      end else if (item_r.address_present) begin
        if (have_station_r) begin
          if (is_reach) begin
            wr.sus_clr = res_r.sus_found;
            wr.sus_idx = res_r.sus_idx;
          end else if (is_failed && !res_r.sus_found && res_r.sus_free_found &&
                       (res_r.sus_cnt < limit_ext)) begin
            wr.sus_ins = 1'b1;
            wr.sus_idx = res_r.sus_free_idx;
          end
        end
        if (item_r.is_deletion) begin
          wr.ent_del = res_r.ent_found;
          wr.ent_idx = res_r.ent_idx;
        end else if (res_r.ent_found) begin
          wr.ent_upd  = 1'b1;
          wr.ent_idx  = res_r.ent_idx;
          tracked_nxt = 1'b1;
        end else if (res_r.free_found && (res_r.ent_cnt < limit_ext)) begin
          wr.ent_ins  = 1'b1;
          wr.ent_idx  = res_r.free_idx;
          tracked_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      limit_r       <= LIMIT_RST;
      alive_mask_r  <= ALIVE_MASK_RST;
      failed_mask_r <= FAILED_MASK_RST;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.data.index)
          CFG_ENTRY_LIMIT: limit_r       <= cfg_ch.data.value[LIMIT_W-1:0];
          CFG_ALIVE_MASK:  alive_mask_r  <= cfg_ch.data.value;
          CFG_FAILED_MASK: failed_mask_r <= cfg_ch.data.value;
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            cnt_r   <= '0;
            state_r <= ST_SCAN_A;
          end
        end
        ST_SCAN_A: begin
          cnt_r <= cnt_r + TW'(1);
          if (cnt_full) begin
            cnt_r   <= '0;
            state_r <= ST_SCAN_B;
          end
        end
        ST_SCAN_B: begin
          cnt_r <= cnt_r + TW'(1);
          if (cnt_full) begin
            state_r <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          cnt_r   <= '0;
          state_r <= ST_ROTATE;
        end
        ST_ROTATE: begin
          cnt_r <= cnt_r + TW'(1);
          if (cnt_r == TW'(TABLE_DEPTH - 1)) begin
            cnt_r   <= '0;
            state_r <= ST_SCAN_C;
          end
        end
        ST_SCAN_C: begin
          cnt_r <= cnt_r + TW'(1);
          if (cnt_full) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid) begin
      item_r    <= in_ch.data;
      station_r <= in_ch.data.sta_mac;
    end
    if (state_r == ST_SCAN_A && cnt_full) begin
      have_station_r <= item_r.mac_present ||
                        (carry_w[TABLE_DEPTH-1].ent_found && carry_w[TABLE_DEPTH-1].ent_mac_known);
      station_r      <= item_r.mac_present ? item_r.sta_mac : carry_w[TABLE_DEPTH-1].ent_mac;
    end
    if (state_r == ST_SCAN_B && cnt_full) begin
      res_r <= carry_w[TABLE_DEPTH-1];
    end
    if (state_r == ST_WRITE) begin
      tracked_r <= tracked_nxt;
    end
    if (state_r == ST_SCAN_C && cnt_full) begin
      out_r.identified    <= report;
      out_r.peer_alive    <= report && !item_r.is_deletion &&
                             ((item_r.neighbor_state & alive_mask_r) != '0);
      out_r.peer_failed   <= report && is_failed;
      out_r.tracked       <= tracked_r;
      out_r.reach_mac_vld <= report && is_reach && item_r.mac_present;
      out_r.reach_mac     <= (report && is_reach && item_r.mac_present) ?
                             item_r.sta_mac : '0;
      out_r.table_live    <= carry_w[TABLE_DEPTH-1].table_live;
      out_r.entry_count   <= carry_w[TABLE_DEPTH-1].ent_cnt[LIMIT_W-1:0];
    end
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while an item is in flight");

  a_suspect_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr.sus_ins && wr.sus_clr) && !(wr.ent_ins && (wr.ent_upd || wr.ent_del)))
    else $error("conflicting store writes");

  a_result_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((!out_r.peer_alive && !out_r.peer_failed && !out_r.tracked &&
                      !out_r.reach_mac_vld) || out_r.identified))
    else $error("report flags set without identified");

endmodule

@@ dv/nlt_checker.sv @@
// Checker for the neighbor liveness table: watches the channels, predicts each result and compares.
`timescale 1ns / 1ps
module nlt_checker import nlt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_beat_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_beat_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  cfg_beat_t cfg_data,
  output int        fail_count,
  output int        pending
);
  localparam int DEPTH = 16;

  logic [LIMIT_W-1:0] limit_r;
  logic [ST_W-1:0]    alive_mask_r, failed_mask_r;

  logic             nb_valid [DEPTH];
  logic             nb_fam   [DEPTH];
  logic [KEY_W-1:0] nb_hi    [DEPTH];
  logic [KEY_W-1:0] nb_lo    [DEPTH];
  logic [ST_W-1:0]  nb_st    [DEPTH];
  logic             nb_mk    [DEPTH];
  logic [MAC_W-1:0] nb_mac   [DEPTH];
  logic             sus_valid [DEPTH];
  logic [MAC_W-1:0] sus_mac   [DEPTH];

  out_beat_t expected_results[$];

  function automatic int cap_now();
    return (limit_r < DEPTH) ? int'(limit_r) : DEPTH;
  endfunction

  function automatic int suspect_slot(logic [MAC_W-1:0] mac);
    for (int i = 0; i < DEPTH; i++)
      if (sus_valid[i] && sus_mac[i] == mac) return i;
    return -1;
  endfunction

  function automatic int neighbor_count();
    int n;
    n = 0;
    for (int i = 0; i < DEPTH; i++) if (nb_valid[i]) n++;
    return n;
  endfunction

  function automatic void mark_suspect(logic [MAC_W-1:0] mac);
    int n;
    int fs;
    n = 0;
    fs = -1;
    if (suspect_slot(mac) >= 0) return;
    for (int i = 0; i < DEPTH; i++) begin
      if (sus_valid[i]) n++;
      else if (fs < 0) fs = i;
    end
    if (n >= cap_now() || fs < 0) return;
    sus_valid[fs] = 1'b1;
    sus_mac[fs] = mac;
  endfunction

  function automatic logic table_alive();
    for (int i = 0; i < DEPTH; i++) begin
      if (!nb_valid[i] || (nb_st[i] & alive_mask_r) == 0) continue;
      if ((nb_st[i] & STATE_STALE) != 0 && nb_mk[i] && suspect_slot(nb_mac[i]) >= 0) continue;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_beat_t apply_report(in_beat_t b);
    out_beat_t r;
    logic fail_hit, reach;
    int hit;
    logic have_sta;
    logic [MAC_W-1:0] sta;
    r = '0;
    if (b.cmd) begin
      for (int i = 0; i < DEPTH; i++) begin
        nb_valid[i] = 1'b0;
        sus_valid[i] = 1'b0;
      end
    end else if (b.address_present) begin
      fail_hit = (b.neighbor_state & failed_mask_r) != 0;
      reach = !b.is_deletion && (b.neighbor_state & STATE_REACH) != 0;
      r.identified = 1'b1;
      r.peer_alive = !b.is_deletion && (b.neighbor_state & alive_mask_r) != 0;
      r.peer_failed = fail_hit;
      if (reach && b.mac_present) begin
        r.reach_mac_vld = 1'b1;
        r.reach_mac = b.sta_mac;
      end
      hit = -1;
      for (int i = 0; i < DEPTH; i++)
        if (hit < 0 && nb_valid[i] && nb_fam[i] == b.address_is_v6 &&
            nb_hi[i] == b.address_high && nb_lo[i] == b.address_low) hit = i;
      have_sta = 1'b0;
      sta = '0;
      if (b.mac_present) begin
        have_sta = 1'b1;
        sta = b.sta_mac;
      end else if (hit >= 0 && nb_mk[hit]) begin
        have_sta = 1'b1;
        sta = nb_mac[hit];
      end
      if (have_sta) begin
        if (fail_hit) mark_suspect(sta);
        if (reach && suspect_slot(sta) >= 0) sus_valid[suspect_slot(sta)] = 1'b0;
      end
      if (b.is_deletion) begin
        if (hit >= 0) nb_valid[hit] = 1'b0;
      end else if (hit >= 0) begin
        nb_st[hit] = b.neighbor_state;
        if (b.mac_present) begin
          nb_mk[hit] = 1'b1;
          nb_mac[hit] = b.sta_mac;
        end
        r.tracked = 1'b1;
      end else if (neighbor_count() < cap_now()) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (!nb_valid[i]) begin
            nb_valid[i] = 1'b1;
            nb_fam[i] = b.address_is_v6;
            nb_hi[i] = b.address_high;
            nb_lo[i] = b.address_low;
            nb_st[i] = b.neighbor_state;
            nb_mk[i] = b.mac_present;
            nb_mac[i] = b.mac_present ? b.sta_mac : '0;
            r.tracked = 1'b1;
            break;
          end
        end
      end
    end
    r.table_live = table_alive();
    r.entry_count = LIMIT_W'(neighbor_count());
    return r;
  endfunction

  always @(posedge clk) begin
    out_beat_t e;
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
      alive_mask_r <= ALIVE_MASK_RST;
      failed_mask_r <= FAILED_MASK_RST;
      for (int i = 0; i < DEPTH; i++) begin
        nb_valid[i] = 1'b0;
        sus_valid[i] = 1'b0;
      end
      expected_results.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_data.index))
          CFG_ENTRY_LIMIT: limit_r <= cfg_data.value[LIMIT_W-1:0];
          CFG_ALIVE_MASK:  alive_mask_r <= cfg_data.value;
          CFG_FAILED_MASK: failed_mask_r <= cfg_data.value;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation waiting");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (out_data !== e) begin
            fail_count <= fail_count + 1;
            if (out_data.identified !== e.identified)
              $error("identified exp %0h got %0h", e.identified, out_data.identified);
            if (out_data.peer_alive !== e.peer_alive)
              $error("peer_alive exp %0h got %0h", e.peer_alive, out_data.peer_alive);
            if (out_data.peer_failed !== e.peer_failed)
              $error("peer_failed exp %0h got %0h", e.peer_failed, out_data.peer_failed);
            if (out_data.tracked !== e.tracked)
              $error("tracked exp %0h got %0h", e.tracked, out_data.tracked);
            if (out_data.reach_mac_vld !== e.reach_mac_vld)
              $error("reach_mac_vld exp %0h got %0h",
                     e.reach_mac_vld, out_data.reach_mac_vld);
            if (out_data.reach_mac !== e.reach_mac)
              $error("reach_mac exp %0h got %0h", e.reach_mac, out_data.reach_mac);
            if (out_data.table_live !== e.table_live)
              $error("table_live exp %0h got %0h", e.table_live, out_data.table_live);
            if (out_data.entry_count !== e.entry_count)
              $error("entry_count exp %0d got %0d", e.entry_count, out_data.entry_count);
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(apply_report(in_data));
      pending <= expected_results.size();
    end
  end
endmodule

@@ dv/tb_neighbor_liveness_table.sv @@
// Testbench top for the neighbor liveness table: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_neighbor_liveness_table;
  import nlt_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   burst_left;
  int   gap_left;

  nlt_in_if  in_ch();
  nlt_out_if out_ch();
  nlt_cfg_if cfg_ch();

  neighbor_liveness_table DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  nlt_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_valid(cfg_ch.valid), .cfg_ready(cfg_ch.ready), .cfg_data(cfg_ch.data),
    .fail_count(fail_count), .pending(pending)
  );

  // small pools so keys and MACs repeat
  logic [KEY_W-1:0] key_pool [8];
  logic [MAC_W-1:0] mac_pool [6];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("** neighbor_liveness_table: FAILED **");
    $finish;
  end

  // receiver stall pattern: alternating stall-free and choppy stretches
  int rx_phase;
  always @(negedge clk) begin
    rx_phase <= rx_phase + 1;
    if (rx_phase[9]) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0) || rx_phase[3];
  end

  // valid stays up between beats of a burst and drops only for a gap
  task automatic send_beat(in_beat_t b);
    if (burst_left == 0) begin
      gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 120);
      burst_left = $urandom_range(1, 8);
      if (gap_left != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap_left) @(negedge clk);
      end
    end
    in_ch.data <= b;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.data <= '{index: idx, value: val};
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  function automatic in_beat_t rand_report();
    in_beat_t b;
    b = '0;
    b.cmd = ($urandom_range(0, 60) == 0);
    b.address_present = ($urandom_range(0, 15) != 0);
    b.address_is_v6 = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) begin
      b.address_high = {$urandom, $urandom};
      b.address_low = {$urandom, $urandom};
    end else begin
      b.address_high = key_pool[$urandom_range(0, 7)];
      b.address_low = key_pool[$urandom_range(0, 7)] ^ KEY_W'($urandom_range(0, 3));
    end
    b.is_deletion = ($urandom_range(0, 7) == 0);
    case ($urandom_range(0, 5))
      0: b.neighbor_state = STATE_REACH;
      1: b.neighbor_state = STATE_STALE;
      2: b.neighbor_state = FAILED_MASK_RST;
      3: b.neighbor_state = FAILED_MASK_RST | STATE_REACH;
      default: b.neighbor_state = ST_W'($urandom);
    endcase
    b.mac_present = $urandom_range(0, 2) != 0;
    b.sta_mac = $urandom_range(0, 7) == 0 ? MAC_W'({$urandom, $urandom}) :
                mac_pool[$urandom_range(0, 5)];
    return b;
  endfunction

  initial begin
    in_beat_t b;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    rx_phase = 0;
    burst_left = 0;
    rst_n = 1'b0;
    for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    for (int i = 0; i < 6; i++) mac_pool[i] = MAC_W'({$urandom, $urandom});
    mac_pool[0] = '1;
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part
    b = '0;
    b.address_present = 1'b1;
    b.neighbor_state = STATE_REACH;
    b.mac_present = 1'b1;
    b.sta_mac = '1;
    send_beat(b);                                 // insert, reachable MAC all ones
    b.address_is_v6 = 1'b1;
    send_beat(b);                                 // same address other family
    b.neighbor_state = FAILED_MASK_RST;
    send_beat(b);                                 // failed -> suspect
    b.neighbor_state = STATE_STALE;
    b.mac_present = 1'b0;
    send_beat(b);                                 // stale suspect, stored MAC used
    b.neighbor_state = FAILED_MASK_RST | STATE_REACH;
    send_beat(b);                                 // failed and reachable together
    b.is_deletion = 1'b1;
    send_beat(b);                                 // deletion
    b = '0;
    b.neighbor_state = '1;
    b.address_high = '1;
    b.address_low = '1;
    send_beat(b);                                 // no address
    b.address_present = 1'b1;
    b.mac_present = 1'b1;
    b.sta_mac = 48'h0;
    send_beat(b);                                 // all-ones key, all state bits
    for (int i = 0; i < 17; i++) begin            // fill past capacity
      b = '0;
      b.address_present = 1'b1;
      b.address_low = KEY_W'(i + 100);
      b.neighbor_state = STATE_STALE;
      send_beat(b);
    end
    b = '0;
    b.cmd = 1'b1;
    send_beat(b);
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: begin
          write_reg(CFG_ENTRY_LIMIT, 8'd0);
          write_reg(CFG_ALIVE_MASK, 8'hFF);
          write_reg(CFG_FAILED_MASK, 8'h00);
        end
        2: begin
          write_reg(CFG_ENTRY_LIMIT, 8'd31);
          write_reg(CFG_ALIVE_MASK, 8'h00);
          write_reg(CFG_FAILED_MASK, 8'hFF);
        end
        3: write_reg(CFG_ENTRY_LIMIT, 8'd1);
        0: ;
        default: begin
          write_reg(CFG_ENTRY_LIMIT, 8'($urandom_range(1, 20)));
          write_reg(CFG_ALIVE_MASK, 8'($urandom) | ALIVE_MASK_RST);
          write_reg(CFG_FAILED_MASK, 8'($urandom));
        end
      endcase
      for (int k = 0; k < 250; k++) send_beat(rand_report());
      drain();
    end

    if (fail_count == 0) begin
      $display("** neighbor_liveness_table: PASSED **");
    end else begin
      $display("** neighbor_liveness_table: FAILED **");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/nlt_pkg.sv
rtl/nlt_in_if.sv
rtl/nlt_out_if.sv
rtl/nlt_cfg_if.sv
rtl/nlt_cell.sv
rtl/neighbor_liveness_table.sv
dv/nlt_checker.sv
dv/tb_neighbor_liveness_table.sv
